FILE: rtl/core/oaat_pkg.sv
// ----------------------------------------------------------------------------
// oaat_pkg
// types, constants and helpers shared by the arbitrary axis transform blocks
// ----------------------------------------------------------------------------
package oaat_pkg;

   localparam int COORD_W     = 32;
   localparam int FRAC        = 16;
   localparam int UNIT_FRAC   = 30;
   localparam int WIDE_W      = 64;
   localparam int UNIT_LAT    = 75;
   localparam int QUEUE_DEPTH = 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic [1:0]                kind_type;

   localparam kind_type KIND_PASS = 2'd0;
   localparam kind_type KIND_FLIP = 2'd1;
   localparam kind_type KIND_AXIS = 2'd2;

   localparam coord_type COORD_ONE = coord_type'(1 << FRAC);
   localparam coord_type COORD_MAX = coord_type'({1'b0, {(COORD_W-1){1'b1}}});
   localparam coord_type COORD_MIN = coord_type'({1'b1, {(COORD_W-1){1'b0}}});
   localparam coord_type AXIS_LIM  = coord_type'(1 << (UNIT_FRAC - 6));
   localparam wide_type  ROUND_HALF = wide_type'(1) <<< (UNIT_FRAC - 1);

   typedef struct packed {
      kind_type        kind;
      coord_type [2:0] p;
      coord_type [2:0] e;
   } oaat_item_type;

   typedef struct packed {
      kind_type        kind;
      coord_type [2:0] p;
      coord_type [2:0] az;
      coord_type [2:0] ax;
   } oaat_side_type;

   typedef struct packed {
      logic [2:0]    neg;
      logic          zero;
      oaat_side_type side;
   } oaat_uctl_type;

   function automatic wide_type smul(input coord_type a, input coord_type b);
      return wide_type'(a) * wide_type'(b);
   endfunction

endpackage

FILE: rtl/core/oaat_front.sv
// ----------------------------------------------------------------------------
// oaat_front
// input register that accepts items and classifies the extrusion
// ----------------------------------------------------------------------------
module oaat_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  oaat_pkg::coord_type [2:0] in_p,
   input  oaat_pkg::coord_type [2:0] in_e,
   output logic                   out_valid,
   input  logic                   out_ready,
   output oaat_pkg::oaat_item_type out_item
);
   import oaat_pkg::*;

   logic          valid_ff;
   oaat_item_type item_ff;
   oaat_item_type item_in;
   logic          on_z;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      on_z = (in_e[0] == '0) && (in_e[1] == '0);
      item_in.p = in_p;
      item_in.e = in_e;
      priority if (on_z && $signed(in_e[2]) == COORD_ONE) begin
         item_in.kind = KIND_PASS;
      end else if (on_z && $signed(in_e[2]) == -COORD_ONE) begin
         item_in.kind = KIND_FLIP;
      end else begin
         item_in.kind = KIND_AXIS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/core/oaat_queue.sv
// ----------------------------------------------------------------------------
// oaat_queue
// short queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
module oaat_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  oaat_pkg::oaat_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output oaat_pkg::oaat_item_type out_item
);
   import oaat_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   oaat_item_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = cnt_ff != CW'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = CW'(cnt_ff + CW'(push) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_cnt_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == CW'($past(cnt_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

FILE: rtl/core/oaat_unit.sv
// ----------------------------------------------------------------------------
// oaat_unit
// pipelined unit vector: normalize, sum of squares, square root, divide
// ----------------------------------------------------------------------------
module oaat_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  oaat_pkg::wide_type [2:0]  in_vec,
   input  oaat_pkg::oaat_side_type   in_side,
   output logic                      out_valid,
   output oaat_pkg::coord_type [2:0] out_vec,
   output oaat_pkg::oaat_side_type   out_side
);
   import oaat_pkg::*;

   localparam int NRM = 6;
   localparam int SQS = 32;
   localparam int DVS = 31;

   logic [UNIT_LAT-1:0] vld_ff;
   oaat_uctl_type       ctl_ff [UNIT_LAT];
   oaat_uctl_type       ctl_in;
   logic [63:0]         mag [3];

   logic [63:0] nm_ff  [NRM+1][3];
   logic [30:0] fm_ff  [3];
   logic [61:0] sq_ff  [3];
   logic [30:0] fm2_ff [3];

   logic [33:0] sr_rem_ff  [SQS+1];
   logic [31:0] sr_root_ff [SQS+1];
   logic [63:0] sr_x_ff    [SQS+1];
   logic [30:0] sr_mag_ff  [SQS+1][3];

   logic [31:0] dv_rem_ff [DVS+1][3];
   logic [30:0] dv_n_ff   [DVS+1][3];
   logic [30:0] dv_q_ff   [DVS+1][3];
   logic [31:0] dv_len_ff [DVS+1];

   coord_type [2:0] out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ctl_in.neg[i] = in_vec[i][WIDE_W-1];
         mag[i] = ctl_in.neg[i] ? 64'(-in_vec[i]) : 64'(in_vec[i]);
      end
      ctl_in.zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
      ctl_in.side = in_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[UNIT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < UNIT_LAT; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            nm_ff[0][i] <= mag[i];
         end
      end
   end

   // leading one moved to the top, one shift size per stage
   for (genvar k = 0; k < NRM; k++) begin : g_norm
      localparam int SH = 32 >> k;
      logic [63:0] orv;
      assign orv = nm_ff[k][0] | nm_ff[k][1] | nm_ff[k][2];
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               nm_ff[k+1][i] <= (orv[63 -: SH] == '0) ? (nm_ff[k][i] << SH) : nm_ff[k][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            fm_ff[i]  <= nm_ff[NRM][i][63:33];
            sq_ff[i]  <= 62'(fm_ff[i]) * 62'(fm_ff[i]);
            fm2_ff[i] <= fm_ff[i];
            sr_mag_ff[0][i] <= fm2_ff[i];
         end
         sr_x_ff[0]    <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
         sr_rem_ff[0]  <= '0;
         sr_root_ff[0] <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar j = 0; j < SQS; j++) begin : g_sqrt
      logic [35:0] r2, tr;
      logic        ge;
      assign r2 = {sr_rem_ff[j], sr_x_ff[j][63:62]};
      assign tr = {2'b00, sr_root_ff[j], 2'b01};
      assign ge = r2 >= tr;
      always_ff @(posedge clock) begin
         if (en) begin
            sr_rem_ff[j+1]  <= ge ? 34'(r2 - tr) : r2[33:0];
            sr_root_ff[j+1] <= {sr_root_ff[j][30:0], ge};
            sr_x_ff[j+1]    <= {sr_x_ff[j][61:0], 2'b00};
            sr_mag_ff[j+1]  <= sr_mag_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [61:0] num;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num = {sr_mag_ff[SQS][i], {UNIT_FRAC{1'b0}}} + 62'(sr_root_ff[SQS] >> 1);
            dv_rem_ff[0][i] <= 32'(num[61:31]);
            dv_n_ff[0][i]   <= num[30:0];
            dv_q_ff[0][i]   <= '0;
         end
         dv_len_ff[0] <= sr_root_ff[SQS];
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar d = 0; d < DVS; d++) begin : g_div
      always_ff @(posedge clock) begin
         logic [32:0] r2;
         logic        ge;
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               r2 = {dv_rem_ff[d][i], dv_n_ff[d][i][30]};
               ge = r2 >= {1'b0, dv_len_ff[d]};
               dv_rem_ff[d+1][i] <= ge ? 32'(r2 - {1'b0, dv_len_ff[d]}) : r2[31:0];
               dv_n_ff[d+1][i]   <= {dv_n_ff[d][i][29:0], 1'b0};
               dv_q_ff[d+1][i]   <= {dv_q_ff[d][i][29:0], ge};
            end
            dv_len_ff[d+1] <= dv_len_ff[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (ctl_ff[UNIT_LAT-2].zero) begin
               out_ff[i] <= '0;
            end else if (ctl_ff[UNIT_LAT-2].neg[i]) begin
               out_ff[i] <= -coord_type'({1'b0, dv_q_ff[DVS][i]});
            end else begin
               out_ff[i] <= coord_type'({1'b0, dv_q_ff[DVS][i]});
            end
         end
      end
   end

   assign out_valid = vld_ff[UNIT_LAT-1];
   assign out_vec   = out_ff;
   assign out_side  = ctl_ff[UNIT_LAT-1].side;

endmodule

FILE: rtl/core/oaat_back.sv
// ----------------------------------------------------------------------------
// oaat_back
// axis construction, projection, rounding and saturation, output register
// ----------------------------------------------------------------------------
module oaat_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  oaat_pkg::oaat_item_type   in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output oaat_pkg::coord_type [2:0] out_r,
   output logic                      out_sat
);
   import oaat_pkg::*;

   logic adv;

   logic            ua_valid, ub_valid, uc_valid;
   wide_type [2:0]  ua_vec, ub_vec, uc_vec;
   oaat_side_type   ua_side_in, ua_side, ub_side_in, ub_side, uc_side_in, uc_side;
   coord_type [2:0] az, ax, ay;
   logic            near_z;

   logic          x1_valid_ff, x2_valid_ff;
   wide_type      x1_ff [6];
   wide_type [2:0] x2_ff;
   oaat_side_type x1_side_ff, x2_side_ff;

   logic          d1_valid_ff, d2_valid_ff;
   wide_type      d1_ff [3][3];
   wide_type      d2_ff [3];
   oaat_side_type d1_side_ff, d2_side_ff;

   logic            o_valid_ff;
   coord_type [2:0] o_r_ff, o_r_in;
   logic            o_sat_ff, o_sat_in;

   assign adv      = !o_valid_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      ua_side_in.kind = in_item.kind;
      ua_side_in.p    = in_item.p;
      ua_side_in.az   = '0;
      ua_side_in.ax   = '0;
      for (int i = 0; i < 3; i++) begin
         ua_vec[i] = wide_type'($signed(in_item.e[i]));
      end
   end

   oaat_unit u_unit_z (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(in_valid), .in_vec(ua_vec), .in_side(ua_side_in),
      .out_valid(ua_valid), .out_vec(az), .out_side(ua_side)
   );

   always_comb begin
      near_z = ($signed(az[0]) < AXIS_LIM) && ($signed(az[0]) > -AXIS_LIM) &&
               ($signed(az[1]) < AXIS_LIM) && ($signed(az[1]) > -AXIS_LIM);
      if (near_z) begin
         ub_vec[0] = wide_type'($signed(az[2]));
         ub_vec[1] = '0;
         ub_vec[2] = -wide_type'($signed(az[0]));
      end else begin
         ub_vec[0] = -wide_type'($signed(az[1]));
         ub_vec[1] = wide_type'($signed(az[0]));
         ub_vec[2] = '0;
      end
      ub_side_in    = ua_side;
      ub_side_in.az = az;
   end

   oaat_unit u_unit_x (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(ua_valid), .in_vec(ub_vec), .in_side(ub_side_in),
      .out_valid(ub_valid), .out_vec(ax), .out_side(ub_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_valid_ff <= 1'b0;
         x2_valid_ff <= 1'b0;
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (adv) begin
         x1_valid_ff <= ub_valid;
         x2_valid_ff <= x1_valid_ff;
         d1_valid_ff <= uc_valid;
         d2_valid_ff <= d1_valid_ff;
         o_valid_ff  <= d2_valid_ff;
      end
   end

   // cross product az x ax
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff[0] <= smul(ub_side.az[1], ax[2]);
         x1_ff[1] <= smul(ub_side.az[2], ax[1]);
         x1_ff[2] <= smul(ub_side.az[2], ax[0]);
         x1_ff[3] <= smul(ub_side.az[0], ax[2]);
         x1_ff[4] <= smul(ub_side.az[0], ax[1]);
         x1_ff[5] <= smul(ub_side.az[1], ax[0]);
         x1_side_ff <= '{kind: ub_side.kind, p: ub_side.p, az: ub_side.az, ax: ax};
         x2_ff[0] <= x1_ff[0] - x1_ff[1];
         x2_ff[1] <= x1_ff[2] - x1_ff[3];
         x2_ff[2] <= x1_ff[4] - x1_ff[5];
         x2_side_ff <= x1_side_ff;
      end
   end

   assign uc_vec     = x2_ff;
   assign uc_side_in = x2_side_ff;

   oaat_unit u_unit_y (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(x2_valid_ff), .in_vec(uc_vec), .in_side(uc_side_in),
      .out_valid(uc_valid), .out_vec(ay), .out_side(uc_side)
   );

   // dot products
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[0][i] <= smul(uc_side.p[i], uc_side.ax[i]);
            d1_ff[1][i] <= smul(uc_side.p[i], ay[i]);
            d1_ff[2][i] <= smul(uc_side.p[i], uc_side.az[i]);
         end
         d1_side_ff <= uc_side;
         for (int k = 0; k < 3; k++) begin
            d2_ff[k] <= d1_ff[k][0] + d1_ff[k][1] + d1_ff[k][2];
         end
         d2_side_ff <= d1_side_ff;
      end
   end

   always_comb begin
      wide_type      rnd;
      logic [32:0]   ng;
      o_sat_in = 1'b0;
      o_r_in   = d2_side_ff.p;
      rnd      = '0;
      ng       = '0;
      unique case (d2_side_ff.kind)
         KIND_PASS: begin
            o_r_in = d2_side_ff.p;
         end
         KIND_FLIP: begin
            for (int i = 0; i < 3; i += 2) begin
               ng = -{d2_side_ff.p[i][COORD_W-1], d2_side_ff.p[i]};
               if (d2_side_ff.p[i] == COORD_MIN) begin
                  o_r_in[i] = COORD_MAX;
                  o_sat_in  = 1'b1;
               end else begin
                  o_r_in[i] = coord_type'(ng[31:0]);
               end
            end
         end
         default: begin
            for (int k = 0; k < 3; k++) begin
               rnd = (d2_ff[k] + ROUND_HALF) >>> UNIT_FRAC;
               if (rnd > wide_type'(COORD_MAX)) begin
                  o_r_in[k] = COORD_MAX;
                  o_sat_in  = 1'b1;
               end else if (rnd < wide_type'(COORD_MIN)) begin
                  o_r_in[k] = COORD_MIN;
                  o_sat_in  = 1'b1;
               end else begin
                  o_r_in[k] = coord_type'(rnd[31:0]);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_r_ff   <= o_r_in;
         o_sat_ff <= o_sat_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_r     = o_r_ff;
   assign out_sat   = o_sat_ff;

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && o_sat_ff |->
         (o_r_ff[0] == COORD_MAX) || (o_r_ff[0] == COORD_MIN) ||
         (o_r_ff[1] == COORD_MAX) || (o_r_ff[1] == COORD_MIN) ||
         (o_r_ff[2] == COORD_MAX) || (o_r_ff[2] == COORD_MIN))
      else $error("saturation flag without a clamped field");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ua_valid) && $stable(uc_valid))
      else $error("pipeline moved while stalled");

endmodule

FILE: rtl/core/ocs_arbitrary_axis_transform.sv
// throughput: one item per cycle with no rsp stall, set by the fully pipelined
// unit vector units (square root and divide each retire one bit per stage)
// a stalled rsp side freezes the whole back pipeline; the queue fills to its depth
// reset clears all valid flags and the queue; no clearing pass is needed
// ----------------------------------------------------------------------------
// ocs_arbitrary_axis_transform
// projects a point onto the object axes built from its extrusion vector
// ----------------------------------------------------------------------------
module ocs_arbitrary_axis_transform (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_x, point_y, point_z, extrusion_x, extrusion_y, extrusion_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_x, result_y, result_z
   output logic [95:0]  rsp_tdata,
   // saturated
   output logic         rsp_tuser
);
   import oaat_pkg::*;

   coord_type [2:0] point, extrusion, result;
   logic            f_valid, f_ready, q_valid, q_ready;
   oaat_item_type   f_item, q_item;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         point[i]     = coord_type'(req_tdata[COORD_W*i +: COORD_W]);
         extrusion[i] = coord_type'(req_tdata[COORD_W*(i+3) +: COORD_W]);
      end
   end

   oaat_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_p(point), .in_e(extrusion),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   oaat_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   oaat_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_r(result), .out_sat(rsp_tuser)
   );

   assign rsp_tdata = {result[2], result[1], result[0]};

endmodule

FILE: dv/ocs_arbitrary_axis_transform_tb.sv
// ----------------------------------------------------------------------------
// ocs_arbitrary_axis_transform_tb
// drives points with extrusion vectors through the transform and compares every
// result against a known table entry or a bit-exact fixed point model of the
// arbitrary axis projection; a directed table runs first, then weighted random
// items with random idling and one long output hold-off
module ocs_arbitrary_axis_transform_tb;
   import oaat_pkg::*;

   typedef longint signed vec_type [3];

   typedef struct {
      coord_type p [3];
      coord_type e [3];
   } point_item_type;

   typedef struct {
      coord_type r [3];
      logic      sat;
   } proj_type;

   typedef struct {
      point_item_type item;
      logic           known;
      proj_type       res;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;

   proj_type       proj_queue [$];
   point_item_type stim [$];
   table_row_type  rows [$];
   int             errors = 0;
   int             n_sent = 0;
   int             n_recv = 0;
   int             n_sat = 0;
   int             n_flip = 0;
   int             n_pass = 0;
   bit             quiet = 1'b0;
   bit             sent_all = 1'b0;

   ocs_arbitrary_axis_transform dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void unit_vec(input vec_type v, output vec_type u);
      longint unsigned mag [3];
      longint unsigned m;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned q;
      bit              neg [3];
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'd0 - longint'(v[i]) : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         u = '{0, 0, 0};
         return;
      end
      while (m >= (64'd1 << 31)) begin
         m = m >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 30)) begin
         m = m << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << UNIT_FRAC) + (len >> 1)) / len;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic longint signed clamp_coord(input longint signed v, inout logic sat);
      if (v > longint'(COORD_MAX)) begin
         sat = 1'b1;
         return longint'(COORD_MAX);
      end
      if (v < longint'(COORD_MIN)) begin
         sat = 1'b1;
         return longint'(COORD_MIN);
      end
      return v;
   endfunction

   function automatic longint signed project(input vec_type p, input vec_type a);
      longint signed   t;
      longint unsigned one;
      one = 64'd1 << UNIT_FRAC;
      t = p[0] * a[0] + p[1] * a[1] + p[2] * a[2] + longint'(one >> 1);
      if (t >= 0) return longint'(longint'(unsigned'(t)) >>> 0) >>> UNIT_FRAC;
      return -longint'((64'd0 - longint'(t) + one - 1) >> UNIT_FRAC);
   endfunction

   function automatic proj_type transform(input point_item_type it);
      vec_type  p, e, az, ax, ay, t;
      proj_type o;
      longint   r [3];
      longint   lim;
      o.sat = 1'b0;
      lim = longint'(AXIS_LIM);
      for (int i = 0; i < 3; i++) begin
         p[i] = longint'(it.p[i]);
         e[i] = longint'(it.e[i]);
      end
      if (e[0] == 0 && e[1] == 0 && e[2] == longint'(COORD_ONE)) begin
         r = '{p[0], p[1], p[2]};
      end else if (e[0] == 0 && e[1] == 0 && e[2] == -longint'(COORD_ONE)) begin
         r[0] = clamp_coord(-p[0], o.sat);
         r[1] = p[1];
         r[2] = clamp_coord(-p[2], o.sat);
      end else begin
         unit_vec(e, az);
         if (az[0] < lim && az[0] > -lim && az[1] < lim && az[1] > -lim)
            t = '{az[2], 0, -az[0]};
         else
            t = '{-az[1], az[0], 0};
         unit_vec(t, ax);
         t[0] = az[1] * ax[2] - az[2] * ax[1];
         t[1] = az[2] * ax[0] - az[0] * ax[2];
         t[2] = az[0] * ax[1] - az[1] * ax[0];
         unit_vec(t, ay);
         r[0] = clamp_coord(project(p, ax), o.sat);
         r[1] = clamp_coord(project(p, ay), o.sat);
         r[2] = clamp_coord(project(p, az), o.sat);
      end
      for (int i = 0; i < 3; i++) o.r[i] = coord_type'(r[i]);
      return o;
   endfunction

   function automatic point_item_type mk(input coord_type px, py, pz, ex, ey, ez);
      point_item_type it;
      it.p = '{px, py, pz};
      it.e = '{ex, ey, ez};
      return it;
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return coord_type'($urandom_range(0, 1 << 20)) - coord_type'(1 << 19);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic add_row(input point_item_type it, input logic known,
                          input coord_type rx, ry, rz, input logic sat);
      table_row_type row;
      row.item = it;
      row.known = known;
      row.res.r = '{rx, ry, rz};
      row.res.sat = sat;
      rows.push_back(row);
   endtask

   initial begin
      point_item_type it;
      coord_type      c;
      add_row(mk(COORD_MAX, COORD_MIN, 0, 0, 0, COORD_ONE), 1,
              COORD_MAX, COORD_MIN, 0, 0);
      add_row(mk(COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, -COORD_ONE), 1,
              COORD_MAX, COORD_MAX, COORD_MAX, 1);
      add_row(mk(COORD_MAX, 5, COORD_MAX, 0, 0, -COORD_ONE), 1,
              -COORD_MAX, 5, -COORD_MAX, 0);
      add_row(mk(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0), 1, 0, 0, 0, 0);
      add_row(mk(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0), 1, 0, 0, 0, 0);
      add_row(mk(COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE, 0, 0, 2 * COORD_ONE), 0, 0, 0, 0, 0);
      add_row(mk(COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE, 0, 0, -2 * COORD_ONE), 0, 0, 0, 0, 0);
      add_row(mk(COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE, COORD_ONE, 0, 0), 0, 0, 0, 0, 0);
      add_row(mk(COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE, 0, -COORD_ONE, 0), 0, 0, 0, 0, 0);
      add_row(mk(7, -9, 11, 1, 0, 0), 0, 0, 0, 0, 0);
      add_row(mk(COORD_ONE, COORD_ONE, COORD_ONE, 100, -100, COORD_ONE), 0, 0, 0, 0, 0);
      add_row(mk(COORD_ONE, COORD_ONE, COORD_ONE, 1023, 0, COORD_ONE), 0, 0, 0, 0, 0);
      add_row(mk(COORD_ONE, COORD_ONE, COORD_ONE, 1024, 0, COORD_ONE), 0, 0, 0, 0, 0);
      add_row(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_ONE, COORD_ONE, COORD_ONE), 0, 0, 0, 0, 0);
      add_row(mk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), 0, 0, 0, 0, 0);
      add_row(mk(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 0, 0, 0, 0, 0);
      add_row(mk(COORD_MAX, COORD_MIN, 0, COORD_MIN, 0, 0), 0, 0, 0, 0, 0);
      add_row(mk(-5 * COORD_ONE, 3 * COORD_ONE, 0, 0, COORD_ONE, COORD_ONE), 0, 0, 0, 0, 0);
      add_row(mk(123456, -654321, 0, 0, 0, 1), 0, 0, 0, 0, 0);
      add_row(mk(123456, -654321, 999, 0, 0, COORD_ONE + 1), 0, 0, 0, 0, 0);
      foreach (rows[i]) stim.push_back(rows[i].item);
      for (int n = 0; n < 800; n++) begin
         for (int i = 0; i < 3; i++) it.p[i] = pick_coord();
         case ($urandom_range(0, 9))
            0: it.e = '{0, 0, COORD_ONE};
            1: it.e = '{0, 0, -COORD_ONE};
            2: begin
               c = coord_type'($urandom_range(0, 4095)) - 2048;
               it.e = '{c, coord_type'($urandom_range(0, 4095)) - 2048, pick_coord()};
            end
            3: it.e = '{pick_coord(), pick_coord(), pick_coord()};
            4: it.e = '{0, 0, coord_type'($urandom_range(0, 3)) - 1};
            default: for (int i = 0; i < 3; i++) it.e[i] = coord_type'($urandom);
         endcase
         stim.push_back(it);
      end
   end

   initial begin
      int gap;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < stim.size(); k++) begin
         if (k > stim.size() * 9 / 10) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= {stim[k].e[2], stim[k].e[1], stim[k].e[0],
                       stim[k].p[2], stim[k].p[1], stim[k].p[0]};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (k < rows.size() && rows[k].known)
            proj_queue.push_back(rows[k].res);
         else
            proj_queue.push_back(transform(stim[k]));
         if (stim[k].e[0] == 0 && stim[k].e[1] == 0) begin
            if (stim[k].e[2] == COORD_ONE) n_pass++;
            if (stim[k].e[2] == -COORD_ONE) n_flip++;
         end
         n_sent++;
      end
      req_tvalid <= 1'b0;
      sent_all = 1'b1;
   end

   initial begin
      int  hold;
      bit  held;
      hold = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && n_sent >= 200) begin
            held = 1'b1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      proj_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_recv++;
         if (proj_queue.size() == 0) begin
            $error("result with no item pending");
            errors++;
         end else begin
            x = proj_queue.pop_front();
            if (x.sat) n_sat++;
            if (rsp_tdata[31:0] !== x.r[0]) begin
               $error("result_x expected %0d actual %0d", x.r[0], $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[63:32] !== x.r[1]) begin
               $error("result_y expected %0d actual %0d", x.r[1], $signed(rsp_tdata[63:32]));
               errors++;
            end
            if (rsp_tdata[95:64] !== x.r[2]) begin
               $error("result_z expected %0d actual %0d", x.r[2], $signed(rsp_tdata[95:64]));
               errors++;
            end
            if (rsp_tuser !== x.sat) begin
               $error("saturated expected %0b actual %0b", x.sat, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (sent_all);
      while (proj_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (proj_queue.size() != 0) errors++;
      $display("%0d items sent, %0d results checked", n_sent, n_recv);
      $display("%0d pass-through, %0d flipped, %0d saturated", n_pass, n_flip, n_sat);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: ocs_arbitrary_axis_transform.f
rtl/core/oaat_pkg.sv
rtl/core/oaat_front.sv
rtl/core/oaat_queue.sv
rtl/core/oaat_unit.sv
rtl/core/oaat_back.sv
rtl/core/ocs_arbitrary_axis_transform.sv
dv/ocs_arbitrary_axis_transform_tb.sv
